// ===== rtl/hce_pkg.sv =====
package hce_pkg;

  localparam int MaxKey     = 4;
  localparam int LetterW    = 5;
  localparam int SizeW      = 3;
  localparam int KeyRowW    = MaxKey * LetterW;
  localparam int ProdW      = 2 * LetterW;
  localparam int SumW       = 12;
  localparam int RecipW     = 10;
  localparam int RecipShift = 14;
  localparam int QuotW      = SumW + RecipW - RecipShift;
  localparam int CharW      = 7;

  localparam logic [LetterW-1:0] ModBase  = 5'd26;
  localparam logic [RecipW-1:0]  RecipMul = 10'd630;
  localparam logic [CharW-1:0]   AsciiLow = 7'd97;
  localparam logic [7:0]         UpperA   = 8'd65;
  localparam logic [7:0]         UpperZ   = 8'd90;
  localparam logic [7:0]         LowerA   = 8'd97;
  localparam logic [7:0]         LowerZ   = 8'd122;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [KeyRowW-1:0] key_row_t;

  typedef struct packed {
    letter_t [MaxKey-1:0] letters;
    logic [SizeW-1:0]     size;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    RegKeySize  = 3'd0,
    RegPad      = 3'd1,
    RegKeyRow0  = 3'd2,
    RegKeyRow1  = 3'd3,
    RegKeyRow2  = 3'd4,
    RegKeyRow3  = 3'd5
  } reg_idx_t;

endpackage

// ===== rtl/hce_front.sv =====
module hce_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] text_byte
  input  logic                         in_tlast,   // end_of_text
  input  logic [hce_pkg::SizeW-1:0]    key_n,
  input  hce_pkg::letter_t             pad_val,
  input  hce_pkg::fifo_stat_t          fifo_stat,
  output logic                         push,
  output hce_pkg::job_t                push_job
);
  import hce_pkg::*;

  logic [1:0]       fill_r, fill_nxt;
  letter_t          blk_r [MaxKey];
  logic             accept;
  logic             is_upper, is_lower, is_letter;
  logic [7:0]       diff;
  letter_t          letter;
  logic [SizeW-1:0] fill_inc;
  logic             complete, flush;

  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;

  assign is_upper  = (in_tdata >= UpperA) && (in_tdata <= UpperZ);
  assign is_lower  = (in_tdata >= LowerA) && (in_tdata <= LowerZ);
  assign is_letter = is_upper || is_lower;
  assign diff      = is_upper ? (in_tdata - UpperA) : (in_tdata - LowerA);
  assign letter    = diff[LetterW-1:0];

  assign fill_inc = {1'b0, fill_r} + 3'd1;
  assign complete = is_letter && (fill_inc >= key_n);
  assign flush    = fill_r != 2'd0;

  always_comb begin
    push_job.size = key_n;
    for (int j = 0; j < MaxKey; j++) begin
      if (in_tlast) begin
        push_job.letters[j] = (3'(j) < {1'b0, fill_r}) ? blk_r[j] : pad_val;
      end else begin
        push_job.letters[j] = (3'(j) == {1'b0, fill_r}) ? letter : blk_r[j];
      end
    end
  end

  assign push = accept && (in_tlast ? flush : complete);

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_tlast) begin
        fill_nxt = 2'd0;
      end else if (is_letter) begin
        fill_nxt = complete ? 2'd0 : fill_inc[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_tlast && is_letter) begin
      blk_r[fill_r] <= letter;
    end
  end

endmodule

// ===== rtl/hce_fifo.sv =====
module hce_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hce_pkg::job_t       push_job,
  input  logic                pop,
  output hce_pkg::job_t       head_job,
  output hce_pkg::fifo_stat_t stat
);
  import hce_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/hce_back.sv =====
module hce_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hce_pkg::job_t                         head_job,
  input  hce_pkg::fifo_stat_t                   fifo_stat,
  input  hce_pkg::key_row_t [hce_pkg::MaxKey-1:0] key_rows,
  output logic                                  pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata,  // [6:0] cipher_char
  output logic                                  out_tlast   // block_last
);
  import hce_pkg::*;

  logic [1:0]           row_r, row_nxt;
  logic                 issue, row_last;
  key_row_t             key_row;
  logic [SumW-1:0]      sum;

  logic                 s1_valid_r, s1_valid_nxt, s1_last_r;
  logic [SumW-1:0]      s1_sum_r;
  logic                 s2_valid_r, s2_valid_nxt, s2_last_r;
  logic [SumW-1:0]      s2_sum_r;
  logic [QuotW-1:0]     s2_quot_r;
  logic                 out_valid_r, out_valid_nxt, out_last_r;
  logic [CharW-1:0]     out_char_r;

  logic                 out_free, s2_free, s1_free;
  logic [SumW+RecipW-1:0] recip_prod;
  logic [SumW-1:0]      rem_full;
  logic [5:0]           rem_wide;
  letter_t              rem;

  assign out_free = !out_valid_r || out_tready;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;

  assign issue    = !fifo_stat.empty && s1_free;
  assign row_last = ({1'b0, row_r} + 3'd1) == head_job.size;
  assign pop      = issue && row_last;
  assign key_row  = key_rows[row_r];

  always_comb begin
    letter_t         k;
    logic [ProdW-1:0] p;
    sum = '0;
    for (int j = 0; j < MaxKey; j++) begin
      k = key_row[j*LetterW +: LetterW];
      if (k >= ModBase) begin
        k = k - ModBase;
      end
      p = k * head_job.letters[j];
      if (3'(j) < head_job.size) begin
        sum = sum + SumW'(p);
      end
    end
  end

  always_comb begin
    row_nxt = row_r;
    if (issue) begin
      row_nxt = row_last ? 2'd0 : row_r + 2'd1;
    end
    s1_valid_nxt  = issue ? 1'b1 : (s2_free ? 1'b0 : s1_valid_r);
    s2_valid_nxt  = s2_free ? s1_valid_r : s2_valid_r;
    out_valid_nxt = out_free ? s2_valid_r : out_valid_r;
  end

  assign recip_prod = s1_sum_r * RecipMul;
  assign rem_full   = s2_sum_r - SumW'(s2_quot_r) * SumW'(ModBase);
  assign rem_wide   = rem_full[5:0];
  assign rem        = (rem_wide >= 6'd26) ? LetterW'(rem_wide - 6'd26) : rem_wide[LetterW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= 2'd0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sum_r  <= sum;
      s1_last_r <= row_last;
    end
    if (s2_free) begin
      s2_sum_r  <= s1_sum_r;
      s2_quot_r <= recip_prod[SumW+RecipW-1:RecipShift];
      s2_last_r <= s1_last_r;
    end
    if (out_free) begin
      out_char_r <= AsciiLow + CharW'(rem);
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/hill_cipher_encrypt_core.sv =====
// Path: a letter completing a block, or an end-of-text flush, queues the block in
//   a 2-entry queue; its first cipher letter reaches out_tvalid via s1, s2, out.
// Throughput: one text byte per cycle unless the queue is full; one cipher letter
//   per cycle per block if out_tready allows, via a three-stage dot-product/mod-26 pipe.
// Reset: synchronous, active low; clears fill count, queue and pipe, loads
//   register defaults; the block buffer is not cleared.
module hill_cipher_encrypt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_byte
  input  logic        in_tlast,    // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [6:0] cipher_char, [7] zero
  output logic        out_tlast,   // block_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hce_pkg::*;

  logic [SizeW-1:0]          key_size_r;
  letter_t                   pad_r;
  key_row_t [MaxKey-1:0]     key_rows_r;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;
  logic [SizeW-1:0]          key_n;
  letter_t                   pad_val;
  logic                      push, pop;
  job_t                      push_job, head_job;
  fifo_stat_t                fifo_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r    <= 3'd4;
      pad_r         <= 5'd23;
      key_rows_r[0] <= 20'd1;
      key_rows_r[1] <= 20'd32;
      key_rows_r[2] <= 20'd1024;
      key_rows_r[3] <= 20'd32768;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegKeySize: key_size_r    <= cfg_pwdata[SizeW-1:0];
        RegPad:     pad_r         <= cfg_pwdata[LetterW-1:0];
        RegKeyRow0: key_rows_r[0] <= cfg_pwdata[KeyRowW-1:0];
        RegKeyRow1: key_rows_r[1] <= cfg_pwdata[KeyRowW-1:0];
        RegKeyRow2: key_rows_r[2] <= cfg_pwdata[KeyRowW-1:0];
        RegKeyRow3: key_rows_r[3] <= cfg_pwdata[KeyRowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegKeySize: cfg_prdata = 32'(key_size_r);
      RegPad:     cfg_prdata = 32'(pad_r);
      RegKeyRow0: cfg_prdata = 32'(key_rows_r[0]);
      RegKeyRow1: cfg_prdata = 32'(key_rows_r[1]);
      RegKeyRow2: cfg_prdata = 32'(key_rows_r[2]);
      RegKeyRow3: cfg_prdata = 32'(key_rows_r[3]);
      default:    cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (key_size_r == 3'd0) begin
      key_n = 3'd1;
    end else if (key_size_r > 3'(MaxKey)) begin
      key_n = 3'(MaxKey);
    end else begin
      key_n = key_size_r;
    end
  end

  assign pad_val = (pad_r >= ModBase) ? pad_r - ModBase : pad_r;

  hce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .key_n     (key_n),
    .pad_val   (pad_val),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_job  (push_job)
  );

  hce_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  hce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .fifo_stat  (fifo_stat),
    .key_rows   (key_rows_r),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'd97) && (out_tdata <= 8'd122))
    else $error("cipher letter out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full && in_tvalid)
    else $error("queue pushed while full");

  a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
    !fifo_stat.empty |-> (head_job.size >= 3'd1) && (head_job.size <= 3'(MaxKey)))
    else $error("queued block has bad size");

endmodule
